// ----- src/ipv6_text_address_parser_core_defines.svh -----
// Assertion macros shared by the parser RTL.
`ifndef IPV6_TEXT_ADDRESS_PARSER_CORE_DEFINES_SVH
`define IPV6_TEXT_ADDRESS_PARSER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define IPV6TAP_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define IPV6TAP_ASSERT_ALWAYS(name, clk, prop, msg) \
   name: assert property (@(posedge clk) prop) else $error(msg);
`else
`define IPV6TAP_ASSERT(name, clk, rst, prop, msg)
`define IPV6TAP_ASSERT_ALWAYS(name, clk, prop, msg)
`endif

`endif

// ----- src/ipv6tap_pkg.sv -----
package ipv6tap_pkg;

   localparam int GROUP_SLOTS = 8;
   localparam int GROUP_W = 16;
   localparam logic [3:0] SLOT_LIMIT = 4'd8;
   localparam logic [3:0] COUNT_LIMIT = 4'd9;
   localparam logic [7:0] COLON_CHAR = 8'h3A;

   typedef struct packed {
      logic [7:0] text_char;
      logic       end_of_text;
   } req_type;

   typedef struct packed {
      logic [63:0] address_upper;
      logic [63:0] address_lower;
   } rsp_type;

   typedef logic [GROUP_SLOTS-1:0][GROUP_W-1:0] group_array_type;

   typedef struct packed {
      group_array_type left_groups;
      group_array_type right_groups;
      logic [31:0]     digit_acc;
      logic            digits_closed;
      logic            prev_colon;
      logic            gap_found;
      logic            side_has_text;
      logic [3:0]      left_count;
      logic [3:0]      right_count;
   } scan_state_type;

endpackage

// ----- src/ipv6tap_scan.sv -----
module ipv6tap_scan (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        advance,
   input  logic [7:0]                  text_char,
   input  logic                        end_of_text,
   output ipv6tap_pkg::scan_state_type state_next
);
   import ipv6tap_pkg::*;

   scan_state_type state_ff;
   scan_state_type state_in;

   function automatic logic [4:0] hex_decode(input logic [7:0] c);
      logic [4:0] r;
      r = 5'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         r = {1'b1, 4'(c - 8'h30)};
      end else if (c >= 8'h61 && c <= 8'h66) begin
         r = {1'b1, 4'(c - 8'h57)};
      end else if (c >= 8'h41 && c <= 8'h46) begin
         r = {1'b1, 4'(c - 8'h37)};
      end
      return r;
   endfunction

   logic [4:0]  hex_res;
   logic [15:0] close_val;

   always_comb begin
      hex_res = hex_decode(text_char);
      close_val = state_ff.digit_acc[15:0];
      state_next = state_ff;
      if (text_char == COLON_CHAR) begin
         if (!state_ff.gap_found && state_ff.prev_colon) begin
            state_next.gap_found = 1'b1;
            if (!state_ff.side_has_text) begin
               state_next.left_count = 4'd0;
            end
            state_next.side_has_text = 1'b0;
         end else if (!state_ff.gap_found) begin
            if (state_ff.left_count < SLOT_LIMIT) begin
               state_next.left_groups[state_ff.left_count[2:0]] = close_val;
            end
            if (state_ff.left_count < COUNT_LIMIT) begin
               state_next.left_count = state_ff.left_count + 4'd1;
            end
         end else begin
            if (state_ff.right_count < SLOT_LIMIT) begin
               state_next.right_groups[state_ff.right_count[2:0]] = close_val;
            end
            if (state_ff.right_count < COUNT_LIMIT) begin
               state_next.right_count = state_ff.right_count + 4'd1;
            end
            state_next.side_has_text = 1'b1;
         end
         state_next.digit_acc = 32'd0;
         state_next.digits_closed = 1'b0;
         state_next.prev_colon = 1'b1;
      end else begin
         if (!state_ff.digits_closed && hex_res[4]) begin
            if (state_ff.digit_acc > 32'h0FFF_FFFF) begin
               state_next.digit_acc = '1;
            end else begin
               state_next.digit_acc = {state_ff.digit_acc[27:0], hex_res[3:0]};
            end
         end else begin
            state_next.digits_closed = 1'b1;
         end
         state_next.side_has_text = 1'b1;
         state_next.prev_colon = 1'b0;
      end
   end

   // The final character of an address returns the scanner to its reset state.
   always_comb begin
      state_in = state_ff;
      if (advance) begin
         state_in = end_of_text ? '0 : state_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- src/ipv6tap_place.sv -----
module ipv6tap_place (
   input  ipv6tap_pkg::scan_state_type scan_state,
   output ipv6tap_pkg::rsp_type        address
);
   import ipv6tap_pkg::*;

   group_array_type left_g;
   group_array_type right_g;
   group_array_type groups;
   logic [3:0]      left_cnt;
   logic [3:0]      right_cnt;
   logic [4:0]      cnt_sum;
   logic [3:0]      right_start;
   logic [3:0]      right_idx;
   logic            final_close;

   // Close the group still open at the end of the text, then expand the gap.
   always_comb begin
      left_g = scan_state.left_groups;
      right_g = scan_state.right_groups;
      left_cnt = scan_state.left_count;
      right_cnt = scan_state.right_count;
      final_close = !scan_state.gap_found || scan_state.side_has_text;
      if (final_close && !scan_state.gap_found) begin
         if (left_cnt < SLOT_LIMIT) begin
            left_g[left_cnt[2:0]] = scan_state.digit_acc[15:0];
         end
         if (left_cnt < COUNT_LIMIT) begin
            left_cnt = left_cnt + 4'd1;
         end
      end else if (final_close) begin
         if (right_cnt < SLOT_LIMIT) begin
            right_g[right_cnt[2:0]] = scan_state.digit_acc[15:0];
         end
         if (right_cnt < COUNT_LIMIT) begin
            right_cnt = right_cnt + 4'd1;
         end
      end

      cnt_sum = {1'b0, left_cnt} + {1'b0, right_cnt};
      right_start = (cnt_sum < {1'b0, SLOT_LIMIT}) ? (SLOT_LIMIT - right_cnt) : left_cnt;
      right_idx = 4'd0;
      groups = '0;
      if (!scan_state.gap_found) begin
         groups = left_g;
      end else begin
         for (int p = 0; p < GROUP_SLOTS; p++) begin
            right_idx = 4'(p) - right_start;
            if (4'(p) < left_cnt) begin
               groups[p] = left_g[p];
            end else if (4'(p) >= right_start) begin
               groups[p] = right_g[right_idx[2:0]];
            end
         end
      end

      address.address_upper = {groups[0], groups[1], groups[2], groups[3]};
      address.address_lower = {groups[4], groups[5], groups[6], groups[7]};
   end

endmodule

// ----- src/ipv6_text_address_parser_core.sv -----
// IPv6 text address parser.
// A request carries one ASCII character of an address in text form, and
// end_of_text marks the final character. Colons split the text into 16-bit
// hex groups and the first double colon expands to a run of zero groups.
// Only the final character produces a response, which carries the full
// 128-bit address as two 64-bit halves, group 0 in the top bits of the upper.
// The block takes one request every cycle unless a final character is held. A
// request sits in an input register while the scanner updates its group state,
// and the assembled address of a final character lands in the response register,
// so a final request passes through the input register, then the response register.
// The path from the input register through the scanner and gap expansion
// into the response register is combinational.
// While a response waits for rsp_ready, characters of the next address keep
// flowing; only a final character is held in the input register, and
// req_ready drops until the response register is free.
// Synchronous reset empties both registers and clears all group state.
`include "ipv6_text_address_parser_core_defines.svh"

module ipv6_text_address_parser_core (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  ipv6tap_pkg::req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output ipv6tap_pkg::rsp_type rsp_data
);
   import ipv6tap_pkg::*;

   req_type        req_ff;
   req_type        req_in;
   logic           in_valid_ff;
   logic           in_valid_in;
   rsp_type        rsp_ff;
   rsp_type        rsp_in;
   logic           rsp_valid_ff;
   logic           rsp_valid_in;
   logic           advance;
   logic           launch;
   scan_state_type scan_state;
   rsp_type        address;

   ipv6tap_scan u_scan (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .text_char   (req_ff.text_char),
      .end_of_text (req_ff.end_of_text),
      .state_next  (scan_state)
   );

   ipv6tap_place u_place (
      .scan_state (scan_state),
      .address    (address)
   );

   assign advance = in_valid_ff && (!req_ff.end_of_text || !rsp_valid_ff || rsp_ready);
   assign launch = advance && req_ff.end_of_text;
   assign req_ready = !in_valid_ff || advance;

   always_comb begin
      req_in = req_ff;
      in_valid_in = in_valid_ff;
      if (req_ready) begin
         req_in = req_data;
         in_valid_in = req_valid;
      end
      rsp_in = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (launch) begin
         rsp_in = address;
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      req_ff <= req_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

   `IPV6TAP_ASSERT(a_mid_char_no_rsp, clock, reset, (advance && !req_ff.end_of_text && !rsp_valid_ff) |=> !rsp_valid_ff, "a character before the end produced a response")
   `IPV6TAP_ASSERT(a_held_req_stable, clock, reset, (in_valid_ff && !advance) |=> (in_valid_ff && $stable(req_ff)), "a held request was lost or changed")
   `IPV6TAP_ASSERT(a_launch_into_free, clock, reset, launch |-> (!rsp_valid_ff || rsp_ready), "a response overwrote one not yet taken")
   `IPV6TAP_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> (!rsp_valid_ff && !in_valid_ff), "registers not empty after reset")

endmodule
